### src/rvid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvid_pkg
// Shared types and encodings for the RV64I instruction decoder: major
// opcodes, function codes, format and mnemonic codes, and the decode result.
// ----------------------------------------------------------------------------
package rvid_pkg;

   localparam int WORD_W = 32;
   localparam int REG_W  = 5;
   localparam int IMM_W  = 21;

   // Major opcodes, low two bits included.
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_LUI    = 7'h37;

   // funct3 codes of the ALU groups.
   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_SLL = 3'd1;
   localparam logic [2:0] F3_XOR = 3'd4;
   localparam logic [2:0] F3_SR  = 3'd5;
   localparam logic [2:0] F3_OR  = 3'd6;
   localparam logic [2:0] F3_AND = 3'd7;

   // funct3 codes of the other groups.
   localparam logic [2:0] F3_BEQ      = 3'd0;
   localparam logic [2:0] F3_BNE      = 3'd1;
   localparam logic [2:0] F3_LOAD_BAD = 3'd7;
   localparam logic [2:0] F3_JALR     = 3'd0;

   // Upper function bits.
   localparam logic [6:0] F7_BASE  = 7'h00;
   localparam logic [6:0] F7_ALT   = 7'h20;
   localparam logic [5:0] SH6_BASE = 6'h00;
   localparam logic [5:0] SH6_ARITH = 6'h10;

   typedef enum logic [2:0] {
      FMT_R      = 3'd0,
      FMT_I_ALU  = 3'd1,
      FMT_LOAD   = 3'd2,
      FMT_STORE  = 3'd3,
      FMT_BRANCH = 3'd4,
      FMT_JAL    = 3'd5,
      FMT_JALR   = 3'd6,
      FMT_LUI    = 3'd7
   } format_type;

   typedef enum logic [5:0] {
      MN_ADD  = 6'd0,  MN_SUB  = 6'd1,  MN_SLL  = 6'd2,  MN_XOR  = 6'd3,
      MN_SRL  = 6'd4,  MN_SRA  = 6'd5,  MN_OR   = 6'd6,  MN_AND  = 6'd7,
      MN_ADDI = 6'd8,  MN_XORI = 6'd9,  MN_ORI  = 6'd10, MN_ANDI = 6'd11,
      MN_SLLI = 6'd12, MN_SRLI = 6'd13, MN_SRAI = 6'd14,
      MN_LB   = 6'd15, MN_LH   = 6'd16, MN_LW   = 6'd17, MN_LD   = 6'd18,
      MN_LBU  = 6'd19, MN_LHU  = 6'd20, MN_LWU  = 6'd21,
      MN_SB   = 6'd22, MN_SH   = 6'd23, MN_SW   = 6'd24, MN_SD   = 6'd25,
      MN_BEQ  = 6'd26, MN_BNE  = 6'd27, MN_BLT  = 6'd28, MN_BGE  = 6'd29,
      MN_BLTU = 6'd30, MN_BGEU = 6'd31,
      MN_JAL  = 6'd32, MN_JALR = 6'd33, MN_LUI  = 6'd34
   } mnemonic_type;

   typedef struct packed {
      logic                     valid_res;
      format_type               format;
      mnemonic_type             mnemonic;
      logic [REG_W-1:0]         dest_reg;
      logic [REG_W-1:0]         src1_reg;
      logic [REG_W-1:0]         src2_reg;
      logic signed [IMM_W-1:0]  immediate;
   } decode_type;

endpackage

### src/rvid_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvid_decode
// Combinational decode of one instruction word into format, mnemonic,
// register fields and immediate. Unsupported encodings give an all-zero result.
// ----------------------------------------------------------------------------
module rvid_decode (
   input  logic [rvid_pkg::WORD_W-1:0] word,
   output rvid_pkg::decode_type        result
);
   import rvid_pkg::*;

   logic [6:0]  opcode;
   logic [2:0]  funct3;
   logic [6:0]  funct7;
   logic [5:0]  hi6;
   logic [IMM_W-1:0] imm_i, imm_s, imm_b, imm_j, imm_u, imm_sh;
   logic        ok;
   decode_type  raw;

   assign opcode = word[6:0];
   assign funct3 = word[14:12];
   assign funct7 = word[31:25];
   assign hi6    = word[31:26];

   assign imm_i  = {{9{word[31]}}, word[31:20]};
   assign imm_sh = {15'd0, word[25:20]};
   assign imm_s  = {{9{word[31]}}, word[31:25], word[11:7]};
   assign imm_b  = {{8{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
   assign imm_j  = {word[31], word[19:12], word[20], word[30:21], 1'b0};
   assign imm_u  = {1'b0, word[31:12]};

   always_comb begin
      raw = '0;
      ok  = 1'b0;
      unique case (opcode)
         OP_REG: begin
            raw.format   = FMT_R;
            raw.dest_reg = word[11:7];
            raw.src1_reg = word[19:15];
            raw.src2_reg = word[24:20];
            unique case (funct3)
               F3_ADD: begin
                  if (funct7 == F7_BASE) begin
                     raw.mnemonic = MN_ADD;
                     ok = 1'b1;
                  end else if (funct7 == F7_ALT) begin
                     raw.mnemonic = MN_SUB;
                     ok = 1'b1;
                  end
               end
               F3_SLL: begin
                  raw.mnemonic = MN_SLL;
                  ok = (funct7 == F7_BASE);
               end
               F3_XOR: begin
                  raw.mnemonic = MN_XOR;
                  ok = (funct7 == F7_BASE);
               end
               F3_SR: begin
                  if (funct7 == F7_BASE) begin
                     raw.mnemonic = MN_SRL;
                     ok = 1'b1;
                  end else if (funct7 == F7_ALT) begin
                     raw.mnemonic = MN_SRA;
                     ok = 1'b1;
                  end
               end
               F3_OR: begin
                  raw.mnemonic = MN_OR;
                  ok = (funct7 == F7_BASE);
               end
               F3_AND: begin
                  raw.mnemonic = MN_AND;
                  ok = (funct7 == F7_BASE);
               end
               default: ok = 1'b0;   // slt and sltu are not supported
            endcase
         end
         OP_IMM: begin
            raw.format    = FMT_I_ALU;
            raw.dest_reg  = word[11:7];
            raw.src1_reg  = word[19:15];
            raw.immediate = imm_i;
            unique case (funct3)
               F3_ADD: begin
                  raw.mnemonic = MN_ADDI;
                  ok = 1'b1;
               end
               F3_XOR: begin
                  raw.mnemonic = MN_XORI;
                  ok = 1'b1;
               end
               F3_OR: begin
                  raw.mnemonic = MN_ORI;
                  ok = 1'b1;
               end
               F3_AND: begin
                  raw.mnemonic = MN_ANDI;
                  ok = 1'b1;
               end
               F3_SLL: begin
                  raw.mnemonic  = MN_SLLI;
                  raw.immediate = imm_sh;
                  ok = (hi6 == SH6_BASE);
               end
               F3_SR: begin
                  raw.immediate = imm_sh;
                  if (hi6 == SH6_BASE) begin
                     raw.mnemonic = MN_SRLI;
                     ok = 1'b1;
                  end else if (hi6 == SH6_ARITH) begin
                     raw.mnemonic = MN_SRAI;
                     ok = 1'b1;
                  end
               end
               default: ok = 1'b0;
            endcase
         end
         OP_LOAD: begin
            raw.format    = FMT_LOAD;
            raw.dest_reg  = word[11:7];
            raw.src1_reg  = word[19:15];
            raw.immediate = imm_i;
            raw.mnemonic  = mnemonic_type'(6'(MN_LB) + {3'd0, funct3});
            ok = (funct3 != F3_LOAD_BAD);
         end
         OP_STORE: begin
            raw.format    = FMT_STORE;
            raw.src1_reg  = word[19:15];
            raw.src2_reg  = word[24:20];
            raw.immediate = imm_s;
            raw.mnemonic  = mnemonic_type'(6'(MN_SB) + {4'd0, funct3[1:0]});
            // Only byte through doubleword widths exist.
            ok = !funct3[2];
         end
         OP_BRANCH: begin
            raw.format    = FMT_BRANCH;
            raw.src1_reg  = word[19:15];
            raw.src2_reg  = word[24:20];
            raw.immediate = imm_b;
            if (funct3 == F3_BEQ || funct3 == F3_BNE) begin
               raw.mnemonic = mnemonic_type'(6'(MN_BEQ) + {5'd0, funct3[0]});
               ok = 1'b1;
            end else if (funct3[2]) begin
               raw.mnemonic = mnemonic_type'(6'(MN_BLT) + {4'd0, funct3[1:0]});
               ok = 1'b1;
            end
         end
         OP_JAL: begin
            raw.format    = FMT_JAL;
            raw.dest_reg  = word[11:7];
            raw.mnemonic  = MN_JAL;
            raw.immediate = imm_j;
            ok = 1'b1;
         end
         OP_JALR: begin
            raw.format    = FMT_JALR;
            raw.dest_reg  = word[11:7];
            raw.src1_reg  = word[19:15];
            raw.mnemonic  = MN_JALR;
            raw.immediate = imm_i;
            ok = (funct3 == F3_JALR);
         end
         OP_LUI: begin
            raw.format    = FMT_LUI;
            raw.dest_reg  = word[11:7];
            raw.mnemonic  = MN_LUI;
            raw.immediate = imm_u;
            ok = 1'b1;
         end
         default: ok = 1'b0;
      endcase
      raw.valid_res = ok;
   end

   // An unsupported encoding reports nothing but zeros.
   assign result = ok ? raw : '0;

endmodule

### src/rv64i_instruction_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64i_instruction_decoder
// Streaming RV64I decoder: one instruction word in, one decoded transaction
// out, with an input register and a result register around the decode logic.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  req_     in         tdata[31:0] = instruction_word
//  rsp_     out        tuser[0] = valid_res; tdata = format, mnemonic,
//                      dest_reg, src1_reg, src2_reg, immediate (low bit up)
//
//  A response is offered once its request has passed the input register and
//  then the result register, later while the response is stalled, and a new
//  request can be accepted every cycle while the response is not stalled.
//  The rate is set by the single decode stage between the input register and
//  the result register; neither register holds more than one transaction.
//  Reset clears both valid flags; payload registers are not reset.
//  While the response is stalled the input register still takes a request as
//  long as it is empty, so one transaction can wait behind the held result.
//
module rv64i_instruction_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] instruction_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [2:0] format, [8:3] mnemonic, [13:9] dest_reg,
                                    // [18:14] src1_reg, [23:19] src2_reg,
                                    // [44:24] immediate, [47:45] zero
   output logic [0:0]  rsp_tuser    // [0] valid_res
);
   import rvid_pkg::*;

   // Input register stage.
   logic              s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0] s1_word_ff,  s1_word_in;

   // Result register stage.
   logic              rsp_valid_ff, rsp_valid_in;
   decode_type        rsp_result_ff, rsp_result_in;

   decode_type        decoded;
   logic              s2_ready;
   logic              s1_move;
   logic              req_take;

   rvid_decode u_decode (
      .word   (s1_word_ff),
      .result (decoded)
   );

   // The result register can load whenever it is empty or its transaction
   // leaves this cycle. The input register can load when it is empty or its
   // word moves on into the result register.
   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && s2_ready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_word_in    = s1_word_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (s2_ready) begin
         rsp_valid_in  = s1_valid_ff;
         rsp_result_in = decoded;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_word_in  = req_tdata;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_word_ff    <= s1_word_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_result_ff.valid_res;
   assign rsp_tdata    = {3'd0,
                          rsp_result_ff.immediate,
                          rsp_result_ff.src2_reg,
                          rsp_result_ff.src1_reg,
                          rsp_result_ff.dest_reg,
                          rsp_result_ff.mnemonic,
                          rsp_result_ff.format};

   // A cycle in reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response pending after reset");

   // An unsupported instruction carries an all-zero payload.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == 48'd0))
      else $error("invalid decode with nonzero payload");

   // With both stages full and the response stalled, no request is taken.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request accepted with both stages full");

   // An accepted request is in the input register on the next cycle.
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted request lost");

   // A word in the input register reaches the output when the output can load.
   a_move_lands: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_tvalid)
      else $error("decoded transaction lost");

endmodule
